// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros; the using module provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset
`define I2T_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included
`define I2T_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// ===== src/i2t_pkg.sv =====
// ----------------------------------------------------------------------------
// i2t_pkg
// Shared types and constants of the I2T acceleration limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2t_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int ENERGY_BITS = 48;

	localparam int SCALE_W = 16;
	localparam int WIN_W   = 13;
	localparam int THR_W   = 48;
	localparam int LIM_W   = 16;
	localparam int CNT_W   = 32;
	localparam int DUTY_W  = 17;

	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;

	localparam int INST_W  = 2 * SAMPLE_BITS + 8;
	localparam int SUM_W   = ((INST_W > ENERGY_BITS) ? INST_W : ENERGY_BITS) + 1;
	localparam int CMP_W   = ((ENERGY_BITS > THR_W) ? ENERGY_BITS : THR_W) + 4;
	localparam int RC60_W  = CNT_W + 6;

	// shared divider: 48-bit dividend covers the duty numerator
	localparam int DIV_W     = (ENERGY_BITS > CNT_W + 16) ? ENERGY_BITS : CNT_W + 16;
	localparam int DVS_W     = CNT_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// limit scaling: floor(L*k/100) = (L * k*ceil(2^31/100)) >> 31, exact for L < 2^16
	localparam int          SCL_SHIFT = 31;
	localparam int          PROD_W    = LIM_W + 32;
	localparam logic [31:0] C_SHRINK  = 32'd2104534026;
	localparam logic [31:0] C_GROW    = 32'd2168958537;

	localparam logic [WIN_W-1:0] N_MIN         = WIN_W'(2);
	localparam logic [WIN_W-1:0] N_MAX         = WIN_W'(4096);
	localparam logic [CNT_W-1:0] LONG_PERIOD   = CNT_W'(30000);
	localparam logic [CNT_W-1:0] FIRST_PERIOD  = CNT_W'(1000);
	localparam logic [DUTY_W-1:0] DUTY_ONE     = DUTY_W'(65536);

	localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(256);
	localparam logic [WIN_W-1:0]   WIN_RST   = WIN_W'(1024);
	localparam logic [THR_W-1:0]   THR_RST   = THR_W'(64'd1099511627776);
	localparam logic [LIM_W-1:0]   MAX_RST   = LIM_W'(65535);
	localparam logic [LIM_W-1:0]   FLOOR_RST = LIM_W'(32768);
	localparam logic [LIM_W-1:0]   LOW_RST   = LIM_W'(32768);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENERGY_SCALE  = 3'd0,
		REG_WINDOW_LENGTH = 3'd1,
		REG_RMS_THRESHOLD = 3'd2,
		REG_LIMIT_MAX     = 3'd3,
		REG_LIMIT_FLOOR   = 3'd4,
		REG_LIMIT_LOW     = 3'd5
	} i2t_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_DWAIT,
		ST_ACCUM,
		ST_CHECK,
		ST_LCMP,
		ST_ENTER,
		ST_ENT_DUTY,
		ST_SHR_MUL,
		ST_SHR_SET,
		ST_EXP_CHK,
		ST_EXP_MUL1,
		ST_EXP_SET1,
		ST_EXP_DUTY,
		ST_EXP_FIN,
		ST_EXP_MUL2,
		ST_EXP_SET2,
		ST_DONE
	} i2t_state_t;

	typedef struct packed {
		logic busy;
		logic rem_nz;
	} i2t_div_stat_t;

endpackage

`default_nettype wire

// ===== src/i2t_div.sv =====
// ----------------------------------------------------------------------------
// i2t_div
// Restoring divider, one quotient bit per cycle, shared by decay and duty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module i2t_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [i2t_pkg::DIV_W-1:0] dividend,
	input  wire logic [i2t_pkg::DVS_W-1:0] divisor,
	output logic      [i2t_pkg::DIV_W-1:0] quotient,
	output i2t_pkg::i2t_div_stat_t         stat
);
	import i2t_pkg::*;

	logic [DIV_W-1:0]     quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVS_W:0]       rem_sh;
	logic [DVS_W:0]       rem_sub;
	logic                 ge;

	assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign quotient    = quo_q;
	assign stat.busy   = cnt_q != '0;
	assign stat.rem_nz = rem_q != '0;

	`I2T_ASSERT(a_start_sets_busy, start |=> stat.busy, "divider did not start")
	`I2T_ASSERT(a_idle_stays, !stat.busy && !start |=> !stat.busy, "divider busy unprompted")
	`I2T_ASSERT(a_full_run, $fell(stat.busy) |-> $past(cnt_q) == DIV_CNT_W'(1), "short division")

endmodule

`default_nettype wire

// ===== src/i2t_thermal_accel_limiter_core.sv =====
// ----------------------------------------------------------------------------
// i2t_thermal_accel_limiter_core
// Leaky I2T energy accumulator with limited-mode acceleration limiting.
// ----------------------------------------------------------------------------
// One acceleration sample per transaction; one result per sample. Every
// sample passes through the shared restoring divider for the decay E/N, and a
// sample that also measures a duty cycle (entry to limited mode, or end of a
// period in normal mode) passes through it again for the duty ratio. The
// divider resolves one quotient bit per cycle over 48 bits. in_ready is high
// only while no sample is in work; a finished result sits in the output
// register and does not block the next sample. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module i2t_thermal_accel_limiter_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [i2t_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [i2t_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [i2t_pkg::SAMPLE_BITS-1:0] acceleration,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [i2t_pkg::ENERGY_BITS-1:0]            energy_level,
	output logic [i2t_pkg::LIM_W-1:0]                  accel_limit,
	output logic                                       limited_mode,
	output logic [i2t_pkg::DUTY_W-1:0]                 duty_ratio
);
	import i2t_pkg::*;

	// configuration
	logic [SCALE_W-1:0] energy_scale_q;
	logic [WIN_W-1:0]   window_length_q;
	logic [THR_W-1:0]   rms_threshold_q;
	logic [LIM_W-1:0]   limit_max_q;
	logic [LIM_W-1:0]   limit_floor_q;
	logic [LIM_W-1:0]   limit_low_q;

	// limiter state
	i2t_state_t             state_q, state_d;
	logic [ENERGY_BITS-1:0] energy_q;
	logic                   limited_flag_q;
	logic [LIM_W-1:0]       active_limit_q;
	logic [LIM_W-1:0]       normal_limit_q;
	logic [CNT_W-1:0]       period_count_q;
	logic [CNT_W-1:0]       recovery_count_q;
	logic [CNT_W-1:0]       period_limit_q;
	logic [DUTY_W-1:0]      duty_value_q;

	// work registers
	logic [SAMPLE_BITS-1:0]     sample_q;
	logic [2*SAMPLE_BITS-1:0]   prod1_q;
	logic [2*SAMPLE_BITS+15:0]  prod2_q;
	logic [ENERGY_BITS-1:0]     decayed_q;
	logic [PROD_W-1:0]          prod3_q;
	logic [CMP_W-1:0]           e10_q;
	logic [CMP_W-1:0]           t9_q;
	logic                       shrink_q;

	// result register
	logic                   out_valid_q;
	logic [ENERGY_BITS-1:0] energy_out_q;
	logic [LIM_W-1:0]       limit_out_q;
	logic                   limited_out_q;
	logic [DUTY_W-1:0]      duty_out_q;

	// divider
	logic                div_start;
	logic                div_sel_duty;
	logic [DIV_W-1:0]    div_dividend;
	logic [DVS_W-1:0]    div_divisor;
	logic [DIV_W-1:0]    div_quo;
	i2t_div_stat_t       div_stat;

	logic                   accept;
	logic                   out_load;
	logic [SAMPLE_BITS-1:0] mag;
	logic [WIN_W-1:0]       n_eff;
	logic [INST_W-1:0]      inst;
	logic [SUM_W-1:0]       sum;
	logic [ENERGY_BITS-1:0] energy_nxt;
	logic                   over_thr;
	logic                   duty_zero;
	logic [RC60_W-1:0]      rc60;
	logic                   shrink_c;
	logic [LIM_W-1:0]       low_eff;
	logic [LIM_W:0]         scaled;
	logic [LIM_W-1:0]       clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_scale_q  <= SCALE_RST;
			window_length_q <= WIN_RST;
			rms_threshold_q <= THR_RST;
			limit_max_q     <= MAX_RST;
			limit_floor_q   <= FLOOR_RST;
			limit_low_q     <= LOW_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ENERGY_SCALE:  energy_scale_q  <= cfg_data[SCALE_W-1:0];
				REG_WINDOW_LENGTH: window_length_q <= cfg_data[WIN_W-1:0];
				REG_RMS_THRESHOLD: rms_threshold_q <= cfg_data[THR_W-1:0];
				REG_LIMIT_MAX:     limit_max_q     <= cfg_data[LIM_W-1:0];
				REG_LIMIT_FLOOR:   limit_floor_q   <= cfg_data[LIM_W-1:0];
				REG_LIMIT_LOW:     limit_low_q     <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;
	assign mag    = sample_q[SAMPLE_BITS-1] ? (~sample_q + 1'b1) : sample_q;
	assign inst   = prod2_q[2*SAMPLE_BITS+15:8];
	assign sum    = SUM_W'(decayed_q) + SUM_W'(inst);
	assign energy_nxt = (sum[SUM_W-1:ENERGY_BITS] != '0) ? '1 : sum[ENERGY_BITS-1:0];

	always_comb begin
		if (window_length_q < N_MIN) begin
			n_eff = N_MIN;
		end else if (window_length_q > N_MAX) begin
			n_eff = N_MAX;
		end else begin
			n_eff = window_length_q;
		end
	end

	assign over_thr  = CMP_W'(energy_q) > CMP_W'(rms_threshold_q);
	assign duty_zero = (period_count_q == '0) || (recovery_count_q > period_count_q);
	assign rc60      = (RC60_W'(recovery_count_q) << 6) - (RC60_W'(recovery_count_q) << 2);
	assign shrink_c  = (recovery_count_q > period_count_q) || (RC60_W'(period_count_q) < rc60);
	assign low_eff   = (limit_low_q > limit_floor_q) ? limit_low_q : limit_floor_q;
	assign scaled    = prod3_q[SCL_SHIFT+LIM_W:SCL_SHIFT];

	always_comb begin
		if (scaled > (LIM_W+1)'(limit_max_q)) begin
			clamped = limit_max_q;
		end else if (scaled < (LIM_W+1)'(limit_floor_q)) begin
			clamped = limit_floor_q;
		end else begin
			clamped = scaled[LIM_W-1:0];
		end
	end

	assign div_dividend = div_sel_duty
		? DIV_W'({period_count_q - recovery_count_q, 16'b0})
		: DIV_W'(energy_q);
	assign div_divisor  = div_sel_duty ? period_count_q : DVS_W'(n_eff);

	i2t_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (accept) state_d = ST_MUL1;
			ST_MUL1:     state_d = ST_MUL2;
			ST_MUL2:     state_d = ST_DWAIT;
			ST_DWAIT:    if (!div_stat.busy) state_d = ST_ACCUM;
			ST_ACCUM:    state_d = ST_CHECK;
			ST_CHECK: begin
				if (limited_flag_q) begin
					state_d = ST_LCMP;
				end else if (over_thr) begin
					state_d = ST_ENTER;
				end else begin
					state_d = ST_EXP_CHK;
				end
			end
			ST_LCMP:     state_d = ST_DONE;
			ST_ENTER: begin
				if (!duty_zero) begin
					state_d = ST_ENT_DUTY;
				end else if (shrink_c) begin
					state_d = ST_SHR_MUL;
				end else begin
					state_d = ST_EXP_CHK;
				end
			end
			ST_ENT_DUTY: begin
				if (!div_stat.busy) begin
					state_d = shrink_q ? ST_SHR_MUL : ST_EXP_CHK;
				end
			end
			ST_SHR_MUL:  state_d = ST_SHR_SET;
			ST_SHR_SET:  state_d = ST_EXP_CHK;
			ST_EXP_CHK:  state_d = (period_limit_q <= period_count_q) ? ST_EXP_MUL1 : ST_DONE;
			ST_EXP_MUL1: state_d = ST_EXP_SET1;
			ST_EXP_SET1: state_d = duty_zero ? ST_EXP_FIN : ST_EXP_DUTY;
			ST_EXP_DUTY: if (!div_stat.busy) state_d = ST_EXP_FIN;
			ST_EXP_FIN:  state_d = ST_EXP_MUL2;
			ST_EXP_MUL2: state_d = ST_EXP_SET2;
			ST_EXP_SET2: state_d = ST_DONE;
			ST_DONE:     if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready     = 1'b0;
		div_start    = 1'b0;
		div_sel_duty = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid;
			end
			ST_ENTER, ST_EXP_SET1: begin
				div_sel_duty = 1'b1;
				div_start    = !duty_zero;
			end
			ST_DONE:     out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			energy_q         <= '0;
			limited_flag_q   <= 1'b0;
			active_limit_q   <= MAX_RST;
			normal_limit_q   <= MAX_RST;
			period_count_q   <= '0;
			recovery_count_q <= '0;
			period_limit_q   <= FIRST_PERIOD;
			duty_value_q     <= DUTY_ONE;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_ACCUM: begin
					energy_q       <= energy_nxt;
					period_count_q <= period_count_q + 1'b1;
				end
				ST_CHECK: begin
					if (limited_flag_q) begin
						recovery_count_q <= recovery_count_q + 1'b1;
					end
				end
				ST_LCMP: begin
					if (e10_q < t9_q) begin
						active_limit_q <= normal_limit_q;
						limited_flag_q <= 1'b0;
						period_limit_q <= (recovery_count_q << 7) - (recovery_count_q << 3);
					end
				end
				ST_ENTER: begin
					active_limit_q   <= low_eff;
					limited_flag_q   <= 1'b1;
					period_count_q   <= '0;
					recovery_count_q <= '0;
					if (duty_zero) begin
						duty_value_q <= '0;
					end
				end
				ST_ENT_DUTY: begin
					if (!div_stat.busy) begin
						duty_value_q <= div_quo[DUTY_W-1:0];
					end
				end
				ST_SHR_SET, ST_EXP_SET2: normal_limit_q <= clamped;
				ST_EXP_SET1: begin
					normal_limit_q <= clamped;
					if (duty_zero) begin
						duty_value_q <= '0;
					end
				end
				ST_EXP_DUTY: begin
					if (!div_stat.busy) begin
						duty_value_q <= div_quo[DUTY_W-1:0];
					end
				end
				ST_EXP_FIN: begin
					period_count_q   <= '0;
					recovery_count_q <= '0;
					period_limit_q   <= LONG_PERIOD;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= $unsigned(acceleration);
		end
		case (state_q)
			ST_MUL1:  prod1_q <= (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
			ST_MUL2:  prod2_q <= (2*SAMPLE_BITS+16)'(prod1_q)
				* (2*SAMPLE_BITS+16)'(energy_scale_q);
			ST_DWAIT: decayed_q <= energy_q - div_quo[ENERGY_BITS-1:0]
				- ENERGY_BITS'(div_stat.rem_nz);
			ST_CHECK: begin
				e10_q <= (CMP_W'(energy_q) << 3) + (CMP_W'(energy_q) << 1);
				t9_q  <= (CMP_W'(rms_threshold_q) << 3) + CMP_W'(rms_threshold_q);
			end
			ST_ENTER:    shrink_q <= shrink_c;
			ST_SHR_MUL:  prod3_q  <= PROD_W'(normal_limit_q) * PROD_W'(C_SHRINK);
			ST_EXP_MUL1,
			ST_EXP_MUL2: prod3_q  <= PROD_W'(normal_limit_q) * PROD_W'(C_GROW);
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			energy_out_q  <= energy_q;
			limit_out_q   <= active_limit_q;
			limited_out_q <= limited_flag_q;
			duty_out_q    <= duty_value_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign energy_level = energy_out_q;
	assign accel_limit  = limit_out_q;
	assign limited_mode = limited_out_q;
	assign duty_ratio   = duty_out_q;

	`I2T_ASSERT(a_accept_busy, in_valid && in_ready |=> !in_ready, "second sample taken early")
	`I2T_ASSERT(a_div_free, div_start |-> !div_stat.busy, "divider restarted mid-run")
	`I2T_ASSERT(a_exit_point, $fell(limited_flag_q) |-> $past(state_q) == ST_LCMP,
		"limited mode left outside recovery check")
	`I2T_ASSERT_ALWAYS(a_duty_range, duty_value_q <= DUTY_ONE, "duty ratio above one")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench for the I2T acceleration limiter core.
// ---------------------------------------------------------------------------
// Sends acceleration samples over a valid/ready channel. For each sample it
// predicts the energy level, active limit, mode flag and duty ratio, and it
// checks every result in order. Directed tests cover the extremes of the
// sample and the registers, entry to and exit from limited mode, a floor set
// above the maximum and energy saturation. Random traffic then runs bursts
// and rests over several register settings. Both sides idle at random, and
// the output side stalls for one long stretch so that the core fills up.
// ---------------------------------------------------------------------------

module tb;
	import i2t_pkg::*;

	localparam int          WDOG_LIMIT    = 3000;
	localparam int          TAIL_CYCLES   = 120;
	localparam int          IDLE_PCT      = 14;
	localparam int          MAX_REPORTS   = 50;
	localparam int          STALL_CYCLES  = 400;
	localparam logic [63:0] ENERGY_FULL   = (64'd1 << ENERGY_BITS) - 64'd1;
	localparam logic [63:0] CNT_MASK      = 64'hFFFF_FFFF;
	localparam logic [63:0] RECOVERY_GAIN = 64'd120;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [ENERGY_BITS-1:0] energy;
		logic [LIM_W-1:0]       limit;
		logic                   limited;
		logic [DUTY_W-1:0]      duty;
	} limiter_out_t;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          cfg_wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index    = '0;
	logic [CFG_DATA_W-1:0]         cfg_data     = '0;
	logic                          in_valid     = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] acceleration = '0;
	logic                          out_valid;
	logic                          out_ready    = 1'b0;
	logic [ENERGY_BITS-1:0]        energy_level;
	logic [LIM_W-1:0]              accel_limit;
	logic                          limited_mode;
	logic [DUTY_W-1:0]             duty_ratio;

	// predicted configuration and state
	logic [63:0] scale_r, window_r, thresh_r, max_r, floor_r, low_r;
	logic [63:0] energy_p, act_lim_p, norm_lim_p;
	logic [63:0] per_cnt_p, rec_cnt_p, per_lim_p, duty_p;
	logic        limited_p;

	limiter_out_t pending_outs[$];

	int n_errors    = 0;
	int n_samples   = 0;
	int n_checked   = 0;
	int n_entries   = 0;
	int n_exits     = 0;
	int n_expiries  = 0;
	int n_shrinks   = 0;
	int n_saturated = 0;
	int n_settings  = 0;
	int burst_amp   = 1000;
	int hold_req    = 0;
	bit quiet       = 1'b0;

	i2t_thermal_accel_limiter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.acceleration (acceleration),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.energy_level (energy_level),
		.accel_limit  (accel_limit),
		.limited_mode (limited_mode),
		.duty_ratio   (duty_ratio)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("MISMATCH at result %0d: %s got %0d, expected %0d",
				n_checked, what, got, want);
	endtask

	task automatic reset_prediction();
		scale_r    = SCALE_RST;
		window_r   = WIN_RST;
		thresh_r   = THR_RST;
		max_r      = MAX_RST;
		floor_r    = FLOOR_RST;
		low_r      = LOW_RST;
		energy_p   = '0;
		limited_p  = 1'b0;
		act_lim_p  = MAX_RST;
		norm_lim_p = MAX_RST;
		per_cnt_p  = '0;
		rec_cnt_p  = '0;
		per_lim_p  = FIRST_PERIOD;
		duty_p     = DUTY_ONE;
	endtask

	// maximum is tested before the floor
	task automatic clamp_normal(input logic [63:0] v);
		if (v > max_r)
			norm_lim_p = max_r;
		else if (v < floor_r)
			norm_lim_p = floor_r;
		else
			norm_lim_p = v;
	endtask

	function automatic logic [63:0] period_duty();
		if (per_cnt_p == 0 || rec_cnt_p > per_cnt_p)
			return 64'd0;
		return ((per_cnt_p - rec_cnt_p) << 16) / per_cnt_p;
	endfunction

	task automatic step_limiter(input logic [SAMPLE_BITS-1:0] raw, output limiter_out_t res);
		logic [SAMPLE_BITS-1:0] neg;
		logic [63:0]            mag, inst, n, decayed, total, rec;
		logic                   shrink;
		neg  = '0 - raw;
		mag  = raw[SAMPLE_BITS-1] ? neg : raw;
		inst = (mag * mag * scale_r) >> 8;
		n    = window_r;
		if (n < 2)
			n = 2;
		if (n > 4096)
			n = 4096;
		decayed = energy_p - (energy_p / n + ((energy_p % n != 0) ? 64'd1 : 64'd0));
		if (inst > ENERGY_FULL - decayed) begin
			energy_p = ENERGY_FULL;
			n_saturated++;
		end else begin
			energy_p = decayed + inst;
		end
		per_cnt_p = (per_cnt_p + 1) & CNT_MASK;
		if (!limited_p) begin
			if (energy_p > thresh_r) begin
				total     = per_cnt_p;
				rec       = rec_cnt_p;
				act_lim_p = (low_r > floor_r) ? low_r : floor_r;
				limited_p = 1'b1;
				duty_p    = period_duty();
				shrink    = (rec > total) ? 1'b1 : (60 * (total - rec) < 59 * total);
				per_cnt_p = '0;
				rec_cnt_p = '0;
				n_entries++;
				if (shrink) begin
					clamp_normal(norm_lim_p * 98 / 100);
					n_shrinks++;
				end
			end
			if (per_lim_p <= per_cnt_p) begin
				clamp_normal(norm_lim_p * 101 / 100);
				duty_p    = period_duty();
				per_cnt_p = '0;
				rec_cnt_p = '0;
				per_lim_p = LONG_PERIOD;
				clamp_normal(norm_lim_p * 101 / 100);
				n_expiries++;
			end
		end else begin
			rec_cnt_p = (rec_cnt_p + 1) & CNT_MASK;
			if (energy_p < (thresh_r * 9 + 9) / 10) begin
				act_lim_p = norm_lim_p;
				limited_p = 1'b0;
				per_lim_p = (rec_cnt_p * RECOVERY_GAIN) & CNT_MASK;
				n_exits++;
			end
		end
		res.energy  = energy_p[ENERGY_BITS-1:0];
		res.limit   = act_lim_p[LIM_W-1:0];
		res.limited = limited_p;
		res.duty    = duty_p[DUTY_W-1:0];
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		logic [CFG_DATA_W-1:0] data;
		data = value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		case (idx)
			REG_ENERGY_SCALE:  scale_r  = data[SCALE_W-1:0];
			REG_WINDOW_LENGTH: window_r = data[WIN_W-1:0];
			REG_RMS_THRESHOLD: thresh_r = data[THR_W-1:0];
			REG_LIMIT_MAX:     max_r    = data[LIM_W-1:0];
			REG_LIMIT_FLOOR:   floor_r  = data[LIM_W-1:0];
			REG_LIMIT_LOW:     low_r    = data[LIM_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] raw);
		limiter_out_t res;
		@(negedge clk);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		acceleration = raw;
		do @(posedge clk); while (!in_ready);
		step_limiter(raw, res);
		pending_outs.push_back(res);
		n_samples++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_outs.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [63:0] with_junk(input logic [63:0] value, input int width);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		if ($urandom_range(3) == 0)
			return value | (junk << width);
		return value;
	endfunction

	function automatic logic [63:0] pick_limit();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 64'd0;
		if (r == 1)
			return 64'd65535;
		return 64'($urandom_range(0, 65535));
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] signed_sample(input int mag);
		if ($urandom_range(1) == 0)
			return SAMPLE_BITS'(-mag);
		return SAMPLE_BITS'(mag);
	endfunction

	task automatic pick_setting();
		logic [63:0] scl, win, thr, amp_inst;
		int          r;
		drain();
		burst_amp = $urandom_range(1, 32767);
		r = $urandom_range(9);
		if (r == 0)
			scl = 64'd0;
		else if (r == 1)
			scl = 64'd65535;
		else if (r == 2)
			scl = 64'd256;
		else
			scl = 64'($urandom_range(1, 65535));
		r = $urandom_range(9);
		case (r)
			0:       win = 64'd0;
			1:       win = 64'd1;
			2:       win = 64'd8191;
			3:       win = 64'd4096;
			default: win = 64'($urandom_range(2, 32));
		endcase
		amp_inst = (64'(burst_amp) * 64'(burst_amp) * scl) >> 8;
		r = $urandom_range(19);
		if (r == 0)
			thr = 64'd0;
		else if (r == 1)
			thr = ENERGY_FULL;
		else if (r == 2)
			thr = {$urandom, $urandom} & ENERGY_FULL;
		else
			thr = amp_inst * $urandom_range(50, 400) / 100;
		write_reg(REG_ENERGY_SCALE,  with_junk(scl, SCALE_W));
		write_reg(REG_WINDOW_LENGTH, with_junk(win, WIN_W));
		write_reg(REG_RMS_THRESHOLD, with_junk(thr, THR_W));
		write_reg(REG_LIMIT_MAX,     with_junk(pick_limit(), LIM_W));
		write_reg(REG_LIMIT_FLOOR,   with_junk(pick_limit(), LIM_W));
		write_reg(REG_LIMIT_LOW,     with_junk(pick_limit(), LIM_W));
		n_settings++;
	endtask

	// bursts near the phase amplitude, then short or long rests; some noise
	task automatic run_traffic(input int count);
		int target, len, amp, k;
		target = n_samples + count;
		while (n_samples < target) begin
			if ($urandom_range(99) < 20) begin
				send_sample(SAMPLE_BITS'($urandom));
			end else begin
				len = $urandom_range(1, 8);
				for (k = 0; k < len; k++) begin
					amp = burst_amp - $urandom_range(0, burst_amp / 8);
					send_sample(($urandom_range(15) == 0) ? 16'h8000 : signed_sample(amp));
				end
				len = ($urandom_range(1) == 0) ? $urandom_range(1, 10) : $urandom_range(100, 140);
				for (k = 0; k < len; k++)
					send_sample(signed_sample($urandom_range(0, burst_amp / 16)));
			end
		end
	endtask

	task automatic test_reset_defaults();
		send_sample('0);
		send_sample(16'h0001);
		send_sample(16'hFFFF);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h5A5A);
		send_sample(16'hA5A5);
		send_sample('0);
	endtask

	task automatic test_register_extremes();
		drain();
		write_reg(REG_ENERGY_SCALE, 64'hFFFF);
		write_reg(REG_WINDOW_LENGTH, 64'd0);
		send_sample(16'h8000);
		send_sample('0);
		drain();
		write_reg(REG_WINDOW_LENGTH, 64'd1);
		send_sample(16'h7FFF);
		drain();
		write_reg(REG_WINDOW_LENGTH, 64'd8191);
		send_sample(16'h8000);
		send_sample(16'hFFFF);
		drain();
		write_reg(REG_WINDOW_LENGTH, 64'd4096);
		write_reg(REG_SPARE_A, {$urandom, $urandom});
		write_reg(REG_SPARE_B, {$urandom, $urandom});
		send_sample(16'h0001);
		drain();
		write_reg(REG_ENERGY_SCALE, 64'd0);
		send_sample(16'h7FFF);
		drain();
		write_reg(REG_ENERGY_SCALE, 64'd256);
		write_reg(REG_WINDOW_LENGTH, 64'd3);
		send_sample(16'h5A5A);
	endtask

	// floor above maximum, low limit under the floor, zero threshold
	task automatic test_limited_mode();
		int guard;
		drain();
		write_reg(REG_ENERGY_SCALE, 64'd256);
		write_reg(REG_WINDOW_LENGTH, 64'd2);
		write_reg(REG_RMS_THRESHOLD, 64'd1000);
		write_reg(REG_LIMIT_MAX, 64'd40000);
		write_reg(REG_LIMIT_FLOOR, 64'd50000);
		write_reg(REG_LIMIT_LOW, 64'd100);
		guard = 0;
		while ((energy_p != 0 || limited_p) && guard < 80) begin
			send_sample('0);
			guard++;
		end
		send_sample(16'd100);
		repeat (4) send_sample('0);
		drain();
		write_reg(REG_RMS_THRESHOLD, 64'd0);
		send_sample(16'h0001);
		send_sample('0);
		drain();
		write_reg(REG_RMS_THRESHOLD, 64'd1000);
		send_sample('0);
		send_sample(16'hFF9C);
	endtask

	// full-scale samples over the longest window until the sum clamps
	task automatic test_saturation();
		int start, guard;
		drain();
		quiet = 1'b1;
		write_reg(REG_ENERGY_SCALE, 64'hFFFF);
		write_reg(REG_WINDOW_LENGTH, 64'd4096);
		write_reg(REG_RMS_THRESHOLD, ENERGY_FULL);
		start = n_saturated;
		guard = 0;
		while (n_saturated < start + 4 && guard < 2500) begin
			send_sample(($urandom_range(1) == 0) ? 16'h8000 : 16'h7FFF);
			guard++;
		end
		drain();
		quiet = 1'b0;
	endtask

	task automatic test_backpressure();
		repeat (3) send_sample(SAMPLE_BITS'($urandom));
		hold_req = STALL_CYCLES;
		repeat (20) send_sample(SAMPLE_BITS'($urandom));
	endtask

	task automatic test_random_traffic();
		repeat (4) begin
			pick_setting();
			run_traffic(125);
		end
	endtask

	initial begin : result_check
		limiter_out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_outs.size() == 0) begin
					report_mismatch("result with nothing pending", energy_level, 0);
				end else begin
					want = pending_outs.pop_front();
					if (energy_level !== want.energy)
						report_mismatch("energy_level", energy_level, want.energy);
					if (accel_limit !== want.limit)
						report_mismatch("accel_limit", accel_limit, want.limit);
					if (limited_mode !== want.limited)
						report_mismatch("limited_mode", limited_mode, want.limited);
					if (duty_ratio !== want.duty)
						report_mismatch("duty_ratio", duty_ratio, want.duty);
				end
				n_checked++;
			end
		end
	end

	initial begin : ready_drive
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = quiet || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < WDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
				stalled = 0;
			else
				stalled++;
		end
		$display("TIMEOUT: %0d cycles without a transaction", WDOG_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		reset_prediction();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_limited_mode();
		test_saturation();
		test_backpressure();
		test_random_traffic();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_outs.size() != 0)
			report_mismatch("results never delivered", 0, pending_outs.size());

		$display("Run covered %0d samples over %0d random settings: %0d limited entries, %0d exits",
			n_samples, n_settings, n_entries, n_exits);
		$display("%0d period expiries, %0d limit shrinks, %0d saturated samples, %0d mismatches",
			n_expiries, n_shrinks, n_saturated, n_errors);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
